// File: design/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; expects clk and arst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is applied
`define DPTG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DPTG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/dptg_pkg.sv
// shared types and constants of the debounced pulse train generator
// no dependencies
`default_nettype none

package dptg_pkg;

	// frame engine phases
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SYNC = 3'd1,
		PH_HIGH = 3'd2,
		PH_LOW  = 3'd3,
		PH_TAIL = 3'd4
	} phase_t;

	// configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CNT_REG_BITS   = 4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_PULSE_WIDTH = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_STEP        = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OFF_WIDTH         = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_COUNT       = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TAIL_WAIT         = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SYNC_WIDTH        = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS    = 3'd6;

	// register values after reset
	localparam logic [CFG_DATA_BITS-1:0] RST_FIRST_PULSE_WIDTH = 24'd100000;
	localparam logic [CFG_DATA_BITS-1:0] RST_WIDTH_STEP        = 24'd50000;
	localparam logic [CFG_DATA_BITS-1:0] RST_OFF_WIDTH         = 24'd400000;
	localparam logic [CNT_REG_BITS-1:0]  RST_PULSE_COUNT       = 4'd5;
	localparam logic [CFG_DATA_BITS-1:0] RST_TAIL_WAIT         = 24'd4500000;
	localparam logic [CFG_DATA_BITS-1:0] RST_SYNC_WIDTH        = 24'd50000;
	localparam logic [CFG_DATA_BITS-1:0] RST_DEBOUNCE_TICKS    = 24'd500000;

endpackage

`default_nettype wire

// File: design/debounced_pulse_train_generator.sv
// top level of the debounced pulse train generator: input stage, tick logic, result register
// depends on dptg_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Each input transaction is one 1 us tick carrying the two button press events; each one
// yields exactly one result transaction with the pin levels, both toggle flags and the frame
// activity after that tick. One tick is taken per clock cycle unless in_ready is low: a
// transaction is held in the input stage register, the whole tick update (debounce counters,
// toggles, frame phase engine, pin overrides) is one pass of combinational logic whose widest
// part is the 24 x pulse-count multiply for the descending start width, and the outcome lands
// in the result register as the tick leaves the input stage. in_ready only drops when both
// the input stage and the result register are full and out_ready is low, so a held result
// blocks new ticks only with the input stage full. Configuration registers (indexes 0 to 6:
// first_pulse_width, width_step, off_width, pulse_count, tail_wait, sync_width,
// debounce_ticks) are written through a separate transaction port that is always ready;
// unknown indexes are dropped. Write them only while no tick is in flight. Durations are
// saturated to TIMER_BITS and the pulse count to COUNT_BITS; a zero duration lasts one tick.
module debounced_pulse_train_generator #(
	parameter int TIMER_BITS = 24,
	parameter int COUNT_BITS = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write channel
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [dptg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [dptg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// tick input channel
	input  wire logic                                 in_valid,
	output      logic                                 in_ready,
	input  wire logic                                 enable_press,
	input  wire logic                                 select_press,
	// result channel
	output      logic                                 out_valid,
	input  wire logic                                 out_ready,
	output      logic                                 pin_a_level,
	output      logic                                 pin_b_level,
	output      logic                                 enabled_flag,
	output      logic                                 ascending_flag,
	output      logic                                 frame_active
);
	import dptg_pkg::*;

	// comparison width covering both the timers and the 24 bit registers
	localparam int CMP_BITS = (TIMER_BITS > CFG_DATA_BITS) ? TIMER_BITS : CFG_DATA_BITS;
	// wide enough for first + (n-1)*step and for current + step
	localparam int SUM_BITS = CMP_BITS + COUNT_BITS + 1;
	localparam int CNT_CMP  = (COUNT_BITS > CNT_REG_BITS) ? COUNT_BITS : CNT_REG_BITS;
	localparam int PROD_BITS = CFG_DATA_BITS + COUNT_BITS;

	// saturate a wide value to the timer width
	function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [SUM_BITS-1:0] v);
		logic [TIMER_BITS-1:0] r;
		if (|(v >> TIMER_BITS)) begin
			r = '1;
		end else begin
			r = v[TIMER_BITS-1:0];
		end
		return r;
	endfunction

	// phase length minus the current tick, zero stays zero
	function automatic logic [TIMER_BITS-1:0] load_len(input logic [CMP_BITS-1:0] v);
		logic [TIMER_BITS-1:0] s;
		s = sat_timer(SUM_BITS'(v));
		return (s == '0) ? s : s - 1'b1;
	endfunction

	// ---------------------------------------------------------------- configuration
	logic [CFG_DATA_BITS-1:0] first_width_q, width_step_q, off_width_q;
	logic [CFG_DATA_BITS-1:0] tail_wait_q, sync_width_q, debounce_q;
	logic [CNT_REG_BITS-1:0]  pulse_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_width_q <= RST_FIRST_PULSE_WIDTH;
			width_step_q  <= RST_WIDTH_STEP;
			off_width_q   <= RST_OFF_WIDTH;
			pulse_count_q <= RST_PULSE_COUNT;
			tail_wait_q   <= RST_TAIL_WAIT;
			sync_width_q  <= RST_SYNC_WIDTH;
			debounce_q    <= RST_DEBOUNCE_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRST_PULSE_WIDTH: first_width_q <= cfg_data;
				REG_WIDTH_STEP:        width_step_q  <= cfg_data;
				REG_OFF_WIDTH:         off_width_q   <= cfg_data;
				REG_PULSE_COUNT:       pulse_count_q <= cfg_data[CNT_REG_BITS-1:0];
				REG_TAIL_WAIT:         tail_wait_q   <= cfg_data;
				REG_SYNC_WIDTH:        sync_width_q  <= cfg_data;
				REG_DEBOUNCE_TICKS:    debounce_q    <= cfg_data;
				default: begin
					// unknown index, write is dropped
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	logic valid_s1;
	logic en_press_s1, sel_press_s1;
	logic out_valid_q;
	logic advance;
	logic step;

	// result register free or being emptied this cycle
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	// the tick in the input stage is applied to the state
	assign step     = valid_s1 && advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			en_press_s1  <= enable_press;
			sel_press_s1 <= select_press;
		end
	end

	// ---------------------------------------------------------------- tick state
	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic [COUNT_BITS-1:0] pulse_num_q, pulse_num_d;
	logic [TIMER_BITS-1:0] width_q, width_d;
	logic                  frame_order_q, frame_order_d;
	logic                  pin_a_q, pin_a_d, pin_b_q, pin_b_d;
	logic                  en_q, en_d, ord_q, ord_d;
	logic [TIMER_BITS-1:0] en_since_q, en_since_d, sel_since_q, sel_since_d;

	// debounce intermediates
	logic [TIMER_BITS-1:0] en_inc, sel_inc;
	logic                  en_acc, sel_acc;

	// frame engine intermediates
	logic [CNT_CMP-1:0]    cnt_ext;
	logic [COUNT_BITS-1:0] count_lim;
	logic [COUNT_BITS-1:0] count_m1;
	logic [PROD_BITS-1:0]  step_prod;
	logic [TIMER_BITS-1:0] start_width;
	logic [SUM_BITS-1:0]   width_up;
	logic [TIMER_BITS-1:0] width_dn;
	logic                  do_start, do_tail, do_pulse;

	// clamp the pulse count to the counter width
	always_comb begin
		cnt_ext = CNT_CMP'(pulse_count_q);
		if (|(cnt_ext >> COUNT_BITS)) begin
			count_lim = '1;
		end else begin
			count_lim = cnt_ext[COUNT_BITS-1:0];
		end
		count_m1  = count_lim - 1'b1;
		// descending frames start at the widest pulse
		step_prod = width_step_q * PROD_BITS'(count_m1);
		if (ord_d || count_lim == '0) begin
			start_width = sat_timer(SUM_BITS'(first_width_q));
		end else begin
			start_width = sat_timer(SUM_BITS'(first_width_q) + SUM_BITS'(step_prod));
		end
		// width of the next pulse inside a frame
		width_up = SUM_BITS'(width_q) + SUM_BITS'(width_step_q);
		if (CMP_BITS'(width_q) > CMP_BITS'(width_step_q)) begin
			width_dn = TIMER_BITS'(CMP_BITS'(width_q) - CMP_BITS'(width_step_q));
		end else begin
			width_dn = '0;
		end
	end

	// next state of one tick
	always_comb begin
		// press counters count the tick, then check the lockout
		en_inc  = (en_since_q == '1) ? en_since_q : en_since_q + 1'b1;
		sel_inc = (sel_since_q == '1) ? sel_since_q : sel_since_q + 1'b1;
		en_acc  = en_press_s1 &&
			(en_inc == '1 || CMP_BITS'(en_inc) > CMP_BITS'(debounce_q));
		sel_acc = sel_press_s1 &&
			(sel_inc == '1 || CMP_BITS'(sel_inc) > CMP_BITS'(debounce_q));
		en_since_d  = en_acc ? '0 : en_inc;
		sel_since_d = sel_acc ? '0 : sel_inc;
		en_d  = en_q ^ en_acc;
		ord_d = ord_q ^ sel_acc;

		phase_d       = phase_q;
		timer_d       = timer_q;
		pulse_num_d   = pulse_num_q;
		width_d       = width_q;
		frame_order_d = frame_order_q;
		pin_a_d       = pin_a_q;
		pin_b_d       = pin_b_q;
		do_start      = 1'b0;
		do_tail       = 1'b0;
		do_pulse      = 1'b0;

		if (phase_q != PH_IDLE && timer_q != '0) begin
			timer_d = timer_q - 1'b1;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					do_start = en_d;
				end
				PH_SYNC: begin
					if (count_lim == '0) begin
						do_tail = 1'b1;
					end else begin
						pulse_num_d = {{(COUNT_BITS-1){1'b0}}, 1'b1};
						do_pulse    = 1'b1;
					end
				end
				PH_HIGH: begin
					pin_a_d = 1'b0;
					phase_d = PH_LOW;
					timer_d = load_len(CMP_BITS'(off_width_q));
				end
				PH_LOW: begin
					if (pulse_num_q >= count_lim) begin
						do_tail = 1'b1;
					end else begin
						pulse_num_d = pulse_num_q + 1'b1;
						width_d     = frame_order_q ? sat_timer(width_up) : width_dn;
						do_pulse    = 1'b1;
					end
				end
				PH_TAIL: begin
					// disabling only lands at the frame boundary
					if (en_d) begin
						do_start = 1'b1;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (do_start) begin
			frame_order_d = ord_d;
			width_d       = start_width;
			pulse_num_d   = '0;
			pin_a_d       = 1'b0;
			pin_b_d       = 1'b1;
			phase_d       = PH_SYNC;
			timer_d       = load_len(CMP_BITS'(sync_width_q));
		end
		if (do_tail) begin
			pin_a_d = 1'b0;
			phase_d = PH_TAIL;
			timer_d = load_len(CMP_BITS'(tail_wait_q));
		end
		if (do_pulse) begin
			// width_d already holds this pulse's width
			pin_a_d = 1'b1;
			pin_b_d = 1'b0;
			phase_d = PH_HIGH;
			timer_d = load_len(CMP_BITS'(width_d));
		end

		// button writes win over the frame engine
		if (en_acc) begin
			pin_a_d = en_d;
		end
		if (sel_acc) begin
			pin_b_d = ord_d;
		end
	end

	// state register, advanced once per applied tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			timer_q       <= '0;
			pulse_num_q   <= '0;
			width_q       <= '0;
			frame_order_q <= 1'b0;
			pin_a_q       <= 1'b0;
			pin_b_q       <= 1'b0;
			en_q          <= 1'b0;
			ord_q         <= 1'b0;
			en_since_q    <= '0;
			sel_since_q   <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			timer_q       <= timer_d;
			pulse_num_q   <= pulse_num_d;
			width_q       <= width_d;
			frame_order_q <= frame_order_d;
			pin_a_q       <= pin_a_d;
			pin_b_q       <= pin_b_d;
			en_q          <= en_d;
			ord_q         <= ord_d;
			en_since_q    <= en_since_d;
			sel_since_q   <= sel_since_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (step) begin
			pin_a_level    <= pin_a_d;
			pin_b_level    <= pin_b_d;
			enabled_flag   <= en_d;
			ascending_flag <= ord_d;
			frame_active   <= (phase_d != PH_IDLE);
		end
	end

	// ---------------------------------------------------------------- assertions
	`DPTG_ASSERT(a_step_gives_result, step |=> out_valid_q,
		"applied tick did not reach the result register")
	`DPTG_ASSERT(a_state_holds, !step |=> $stable(phase_q) && $stable(timer_q) && $stable(en_q),
		"tick state moved without an applied tick")
	`DPTG_ASSERT_ALWAYS(a_idle_timer_clear, phase_q == PH_IDLE |-> timer_q == '0,
		"phase timer left running while idle")
	`DPTG_ASSERT(a_pulse_numbered, (phase_q == PH_HIGH || phase_q == PH_LOW) |-> pulse_num_q != '0,
		"pulse phase with no pulse number")

endmodule

`default_nettype wire
